FILE: src/bebu_pkg.sv
package bebu_pkg;

    localparam int DATA_W  = 8;
    localparam int VALUE_W = 64;
    localparam int BW_W    = 7;
    localparam int RUN_W   = 32;
    localparam int ADDR_W  = 3;
    localparam int PDATA_W = 32;
    localparam int RCNT_W  = 4;

    localparam logic [BW_W-1:0]  BIT_WIDTH_RESET  = 7'd8;
    localparam logic [RUN_W-1:0] RUN_LENGTH_RESET = 32'd1;

    typedef enum logic [0:0] {
        REG_BIT_WIDTH  = 1'b0,
        REG_RUN_LENGTH = 1'b1
    } t_reg_idx;

    // effective settings after clamping
    typedef struct packed {
        logic [BW_W-1:0]  width;
        logic [RUN_W-1:0] run_len;
    } t_cfg;

    // result of one step over the held byte
    typedef struct packed {
        logic               emit;
        logic               done;
        logic [VALUE_W-1:0] value;
        logic [DATA_W-1:0]  rem;
        logic [RCNT_W-1:0]  rcnt;
    } t_step;

endpackage

FILE: src/bebu_cfg.sv
module bebu_cfg #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bebu_pkg::ADDR_W-1:0]   paddr,
    input  logic [bebu_pkg::PDATA_W-1:0]  pwdata,
    output logic [bebu_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output bebu_pkg::t_cfg                o_cfg
);

    logic [bebu_pkg::BW_W-1:0]  r_bit_width;
    logic [bebu_pkg::RUN_W-1:0] r_run_length;
    logic                       wr_en;
    bebu_pkg::t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = bebu_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_width  <= bebu_pkg::BIT_WIDTH_RESET;
            r_run_length <= bebu_pkg::RUN_LENGTH_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                bebu_pkg::REG_BIT_WIDTH:  r_bit_width  <= pwdata[bebu_pkg::BW_W-1:0];
                bebu_pkg::REG_RUN_LENGTH: r_run_length <= pwdata[bebu_pkg::RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bebu_pkg::REG_BIT_WIDTH:
                prdata = bebu_pkg::PDATA_W'(r_bit_width);
            bebu_pkg::REG_RUN_LENGTH:
                prdata = bebu_pkg::PDATA_W'(r_run_length);
            default:
                prdata = '0;
        endcase
    end

    // zero width acts as one, oversize width clamps, zero run length acts as one
    always_comb begin
        if (r_bit_width == '0) begin
            o_cfg.width = bebu_pkg::BW_W'(1);
        end else if (r_bit_width > bebu_pkg::BW_W'(MAX_WIDTH)) begin
            o_cfg.width = bebu_pkg::BW_W'(MAX_WIDTH);
        end else begin
            o_cfg.width = r_bit_width;
        end
        if (r_run_length == '0) begin
            o_cfg.run_len = bebu_pkg::RUN_W'(1);
        end else begin
            o_cfg.run_len = r_run_length;
        end
    end

endmodule

FILE: src/bebu_slice.sv
module bebu_slice #(
    parameter int MAX_WIDTH = 64
) (
    input  logic [MAX_WIDTH-2:0]              i_pending,
    input  logic [$clog2(MAX_WIDTH)-1:0]      i_count,
    input  logic [bebu_pkg::DATA_W-1:0]       i_rem,
    input  logic [bebu_pkg::RCNT_W-1:0]       i_rcnt,
    input  logic [bebu_pkg::BW_W-1:0]         i_width,
    output bebu_pkg::t_step                   o_step,
    output logic [MAX_WIDTH-2:0]              o_pending,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_count
);

    localparam int PEND_W = MAX_WIDTH - 1;
    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int ACC_W  = PEND_W + bebu_pkg::DATA_W;

    logic [bebu_pkg::BW_W-1:0]    cnt_ext;
    logic [bebu_pkg::BW_W-1:0]    need_full;
    logic [bebu_pkg::RCNT_W-1:0]  need;
    logic [bebu_pkg::RCNT_W-1:0]  rcnt_left;
    logic [bebu_pkg::DATA_W-1:0]  rem_left;
    logic [ACC_W-1:0]             acc_emit;
    logic [ACC_W-1:0]             acc_all;
    logic [ACC_W-1:0]             acc_left;
    logic [MAX_WIDTH-1:0]         vmask;
    logic                         emit;

    assign cnt_ext   = bebu_pkg::BW_W'(i_count);
    assign need_full = (cnt_ext >= i_width) ? bebu_pkg::BW_W'(1) : (i_width - cnt_ext);
    assign emit      = need_full <= bebu_pkg::BW_W'(i_rcnt);
    assign need      = need_full[bebu_pkg::RCNT_W-1:0];

    assign acc_emit  = {i_pending, i_rem} >> (bebu_pkg::RCNT_W'(8) - need);
    assign acc_all   = {i_pending, i_rem} >> (bebu_pkg::RCNT_W'(8) - i_rcnt);
    assign rem_left  = i_rem << need;
    assign rcnt_left = i_rcnt - need;
    assign acc_left  = {{PEND_W{1'b0}}, rem_left} >> (bebu_pkg::RCNT_W'(8) - rcnt_left);
    assign vmask     = ~({MAX_WIDTH{1'b1}} << i_width);

    always_comb begin
        o_step.emit  = emit;
        o_step.value = bebu_pkg::VALUE_W'(acc_emit[MAX_WIDTH-1:0] & vmask);
        o_step.rem   = rem_left;
        o_step.rcnt  = rcnt_left;
        o_step.done  = 1'b1;
        o_pending    = '0;
        o_count      = '0;
        if (!emit) begin
            // whole remainder joins the partial value
            o_pending = acc_all[PEND_W-1:0];
            o_count   = CNT_W'(cnt_ext + bebu_pkg::BW_W'(i_rcnt));
        end else if (rcnt_left == '0) begin
            o_step.done = 1'b1;
        end else if (bebu_pkg::BW_W'(rcnt_left) < i_width) begin
            // leftover bits start the next value
            o_pending = acc_left[PEND_W-1:0];
            o_count   = CNT_W'(rcnt_left);
        end else begin
            o_step.done = 1'b0;
        end
    end

endmodule

FILE: src/big_endian_bit_unpacker_core.sv
// channel | direction | signals                          | beat
// in      | input     | i_in_valid, o_in_stall           | i_data_byte
// out     | output    | o_out_valid, i_out_stall         | o_value, o_last_value
// cfg     | input     | psel, penable, pwrite, paddr ... | pwdata / prdata
//
// a byte is registered as the held byte and stays until every value it
// completes has left through the single output register, one value a beat
// bit widths of 8 or more give one byte per cycle unless out stalls
// synchronous active-low reset clears the partial value and the run count
// out stall holds the output register and backs up into o_in_stall
module big_endian_bit_unpacker_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bebu_pkg::DATA_W-1:0]   i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bebu_pkg::VALUE_W-1:0]  o_value,
    output logic                          o_last_value,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bebu_pkg::ADDR_W-1:0]   paddr,
    input  logic [bebu_pkg::PDATA_W-1:0]  pwdata,
    output logic [bebu_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int PEND_W = MAX_WIDTH - 1;
    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int CMP_W  = (COUNT_BITS > bebu_pkg::RUN_W) ? COUNT_BITS : bebu_pkg::RUN_W;

    bebu_pkg::t_cfg               cfg;
    bebu_pkg::t_step              step;
    logic [PEND_W-1:0]            n_pending;
    logic [CNT_W-1:0]             n_count;

    logic                         r_busy;
    logic [bebu_pkg::DATA_W-1:0]  r_rem;
    logic [bebu_pkg::RCNT_W-1:0]  r_rcnt;
    logic [PEND_W-1:0]            r_pending;
    logic [CNT_W-1:0]             r_count;
    logic [COUNT_BITS-1:0]        r_vdone;
    logic                         r_out_valid;
    logic [bebu_pkg::VALUE_W-1:0] r_value;
    logic                         r_last;

    logic                         out_free;
    logic                         step_go;
    logic                         byte_free;
    logic                         in_acc;
    logic [COUNT_BITS-1:0]        n_vdone;
    logic                         is_last;

    bebu_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bebu_slice #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_slice (
        .i_pending (r_pending),
        .i_count   (r_count),
        .i_rem     (r_rem),
        .i_rcnt    (r_rcnt),
        .i_width   (cfg.width),
        .o_step    (step),
        .o_pending (n_pending),
        .o_count   (n_count)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step_go    = r_busy && (!step.emit || out_free);
    assign byte_free  = !r_busy || (step_go && step.done);
    assign in_acc     = i_in_valid && byte_free;
    assign o_in_stall = !byte_free;

    assign n_vdone = r_vdone + COUNT_BITS'(1);
    assign is_last = CMP_W'(n_vdone) >= CMP_W'(cfg.run_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pending   <= '0;
            r_count     <= '0;
            r_vdone     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (step_go && step.done) begin
                r_busy <= 1'b0;
            end
            if (step_go) begin
                r_pending <= n_pending;
                r_count   <= n_count;
            end
            if (step_go && step.emit) begin
                r_out_valid <= 1'b1;
                r_vdone     <= is_last ? '0 : n_vdone;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rem  <= i_data_byte;
            r_rcnt <= bebu_pkg::RCNT_W'(bebu_pkg::DATA_W);
        end else if (step_go) begin
            r_rem  <= step.rem;
            r_rcnt <= step.rcnt;
        end
        if (step_go && step.emit) begin
            r_value <= step.value;
            r_last  <= is_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = r_value;
    assign o_last_value = r_last;

endmodule

FILE: src/bebu_checker.sv
module bebu_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [bebu_pkg::VALUE_W-1:0]  o_value,
    input logic                          o_last_value
);

    // out beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("out valid dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_value) && $stable(o_last_value))
        else $error("out beat changed under stall");

    // nothing in flight after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("out valid after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind big_endian_bit_unpacker_core bebu_checker u_bebu_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import bebu_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int SEGMENTS       = 12;
    localparam int SEGMENT_BYTES  = 38;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               last;
    } value_beat_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [DATA_W-1:0]   i_data_byte = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [VALUE_W-1:0]  o_value;
    logic                o_last_value;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // packed bytes waiting for the driver and unpacked values still to come out
    logic [DATA_W-1:0]   pending_bytes[$];
    value_beat_t         expected_values[$];

    // predictor state
    logic [BW_W-1:0]     cfg_width;
    logic [RUN_W-1:0]    cfg_run;
    logic [62:0]         held_bits;
    logic [5:0]          held_count;
    logic [RUN_W-1:0]    run_count;

    logic                in_took = 1'b0;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  bytes_queued = 0;
    int                  bytes_taken = 0;
    int                  values_checked = 0;
    int                  cfg_writes = 0;
    int                  mismatches = 0;
    value_beat_t         out_beat;

    big_endian_bit_unpacker_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_last_value (o_last_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [ADDR_W-1:0] reg_addr(input t_reg_idx idx);
        return {idx, 2'b00};
    endfunction

    // cut one byte into values, msb first, carrying partial bits over
    function automatic void unpack_byte(input logic [DATA_W-1:0] data);
        logic [BW_W-1:0]    w;
        logic [RUN_W-1:0]   rl;
        logic [63:0]        acc;
        logic [6:0]         held;
        logic [RUN_W-1:0]   done;
        value_beat_t        beat;
        int                 b;
        w = cfg_width;
        if (w == 0) w = 7'd1;
        if (w > 64) w = 7'd64;
        rl = (cfg_run == 0) ? 32'd1 : cfg_run;
        for (b = DATA_W - 1; b >= 0; b--) begin
            acc = {held_bits, data[b]};
            held = {1'b0, held_count} + 7'd1;
            if (held >= w) begin
                done = run_count + 32'd1;
                beat.last = (done >= rl);
                run_count = beat.last ? 32'd0 : done;
                beat.value = (w == 64) ? acc : acc & ((64'd1 << w) - 64'd1);
                expected_values.push_back(beat);
                held_bits = '0;
                held_count = '0;
            end else begin
                held_bits = acc[62:0];
                held_count = held[5:0];
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t: %s: got %h, want %h", $time, what, got, want);
    endtask

    // driver
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_data_byte <= pending_bytes.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width = BIT_WIDTH_RESET;
            cfg_run = RUN_LENGTH_RESET;
            held_bits = '0;
            held_count = '0;
            run_count = '0;
            in_took <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == reg_addr(REG_BIT_WIDTH))
                    cfg_width = pwdata[BW_W-1:0];
                else if (paddr == reg_addr(REG_RUN_LENGTH))
                    cfg_run = pwdata[RUN_W-1:0];
            end
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (expected_values.size() == 0) begin
                    report_mismatch("value beat with nothing expected", o_value, '0);
                end else begin
                    out_beat = expected_values.pop_front();
                    values_checked++;
                    if (o_value !== out_beat.value)
                        report_mismatch("value", o_value, out_beat.value);
                    if (o_last_value !== out_beat.last)
                        report_mismatch("last_value", 64'(o_last_value),
                                        64'(out_beat.last));
                end
            end
            in_took <= i_in_valid && o_in_stall === 1'b0;
            if (i_in_valid && o_in_stall === 1'b0) begin
                unpack_byte(i_data_byte);
                bytes_taken++;
            end
        end
    end

    task automatic send_byte(input logic [DATA_W-1:0] data);
        pending_bytes.push_back(data);
        bytes_queued++;
    endtask

    task automatic wait_until_drained();
        while (bytes_taken != bytes_queued || expected_values.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= reg_addr(idx);
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_writes++;
    endtask

    task automatic set_config(input logic [PDATA_W-1:0] width,
                              input logic [PDATA_W-1:0] run_len);
        wait_until_drained();
        cfg_write(REG_BIT_WIDTH, width);
        cfg_write(REG_RUN_LENGTH, run_len);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1: begin
                send_idle_pct = 54;
                stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                stall_pct = 54;
            end
            default: begin
                send_idle_pct = 26;
                stall_pct = 26;
            end
        endcase
    endtask

    initial begin : stimulus
        int seg;
        int i;
        int pick;
        logic [PDATA_W-1:0] width;
        logic [PDATA_W-1:0] run_len;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: whole bytes, every value last
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);

        // single-bit values, runs of three
        set_config(1, 3);
        send_byte(8'h80);
        send_byte(8'h5A);

        // full 64-bit value
        set_config(64, 2);
        repeat (8) send_byte(8'hFF);

        // zero width acts as one, zero run length acts as one
        set_config(0, 0);
        send_byte(8'h3C);

        // oversized width clamps to 64, then width shrinks with bits held
        set_config(127, 2);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h78);
        wait_until_drained();
        cfg_write(REG_BIT_WIDTH, 13);
        send_byte(8'h9A);

        // run length shortened and then maxed out mid-run
        set_config(4, 5);
        send_byte(8'hC3);
        wait_until_drained();
        cfg_write(REG_RUN_LENGTH, 2);
        send_byte(8'h0F);
        wait_until_drained();
        cfg_write(REG_RUN_LENGTH, 32'hFFFF_FFFF);
        send_byte(8'hE7);
        send_byte(8'h18);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            pick = $urandom_range(9);
            case (pick)
                0: width = 1;
                1: width = 64;
                2: width = $urandom_range(127);
                3: width = 0;
                default: width = $urandom_range(1, 64);
            endcase
            pick = $urandom_range(7);
            case (pick)
                0: run_len = 0;
                1: run_len = 32'hFFFF_FFFF;
                2: run_len = $urandom();
                default: run_len = $urandom_range(1, 9);
            endcase
            set_config(width, run_len);
            set_idling(seg % 4);
            for (i = 0; i < SEGMENT_BYTES; i++) begin
                if (seg == 5 && i == SEGMENT_BYTES / 2)
                    wait_until_drained();
                send_byte(DATA_W'($urandom_range(255)));
            end
        end

        wait_until_drained();
        $display("%0d packed bytes unpacked into %0d checked values", bytes_taken,
                 values_checked);
        $display("%0d register writes, widths 0..127, free-running and throttled flow",
                 cfg_writes);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
